// ===== rtl/core/bvpd_pkg.sv =====
// Package for the bitmap video RAM pixel decoder.
// Holds the function codes, fixed field widths, stage payload types and the
// byte-lane, merge and pixel decode functions. Depends on nothing.
`default_nettype none

package bvpd_pkg;

   localparam int ADDR_BITS  = 18;
   localparam int WORD_BITS  = 16;
   localparam int INDEX_BITS = 12;
   localparam int FUNC_BITS  = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_RAM_WRITE   = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_RAM_READ    = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CTRL_WRITE  = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_MASK_WRITE  = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_CTRL_READ   = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_PIXEL_FETCH = 3'd5;

   localparam logic [ADDR_BITS-1:0] SCREEN1_BASE = 18'h20000;
   localparam logic [WORD_BITS-1:0] STATUS_VALUE = 16'h0060;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [WORD_BITS-1:0] write_data;
      logic [WORD_BITS-1:0] bit_enable;
      logic [ADDR_BITS-1:0] raw_address;
   } bvpd_access_type;

   typedef struct packed {
      bvpd_access_type      access;
      logic [ADDR_BITS-1:0] quotient;
   } bvpd_slot_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [WORD_BITS-1:0] word;
   } bvpd_fetch_type;

   function automatic logic [WORD_BITS-1:0] lane_mask(input logic [1:0] byte_enable);
      return {{8{byte_enable[1]}}, {8{byte_enable[0]}}};
   endfunction

   function automatic logic [WORD_BITS-1:0] merge_word(input logic [WORD_BITS-1:0] old_word,
                                                       input logic [WORD_BITS-1:0] new_word,
                                                       input logic [WORD_BITS-1:0] mask);
      return (old_word & ~mask) | (new_word & mask);
   endfunction

   function automatic logic [INDEX_BITS-1:0] decode_pixel(input logic [WORD_BITS-1:0] word);
      logic [INDEX_BITS-1:0] index;
      index        = '0;
      index[10:8]  = word[8:6];
      if (word[15]) begin
         index[11]  = 1'b1;
         index[3:0] = word[13] ? 4'b0 : word[12:9];
      end else begin
         index[3:0] = word[3:0];
      end
      return index;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bvpd_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on bvpd_pkg for the field widths.
`default_nettype none

interface bvpd_req_if;
   import bvpd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [ADDR_BITS-1:0] word_address;
   logic [WORD_BITS-1:0] write_data;
   logic [1:0]           byte_enable;
   logic [8:0]           pixel_x;
   logic [7:0]           pixel_y;

   modport source (output valid, func, word_address, write_data, byte_enable, pixel_x,
                   pixel_y, input ready);
   modport sink (input valid, func, word_address, write_data, byte_enable, pixel_x,
                 pixel_y, output ready);
endinterface

interface bvpd_rsp_if;
   import bvpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_BITS-1:0]  read_data;
   logic [INDEX_BITS-1:0] palette_index;

   modport source (output valid, read_data, palette_index, input ready);
   modport sink (input valid, read_data, palette_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bvpd_front.sv =====
// Request stage: accepts transfers, owns the control and bit-mask registers
// and forms the raw RAM address. Depends on bvpd_pkg and bvpd_if.
`default_nettype none

module bvpd_front #(
   parameter int LINE_PITCH = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   bvpd_req_if.sink                  req_ch,
   output logic                      access_valid,
   input  logic                      access_ready,
   output bvpd_pkg::bvpd_access_type access_out
);
   import bvpd_pkg::*;

   localparam logic [ADDR_BITS-1:0] PITCH = ADDR_BITS'(LINE_PITCH);

   logic                 ready;
   logic                 accept;
   logic [WORD_BITS-1:0] lanes;
   logic [ADDR_BITS-1:0] pixel_address;
   logic                 valid_ff, valid_in;
   logic [WORD_BITS-1:0] control_ff, control_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   bvpd_access_type      access_ff, access_in;

   assign ready        = !valid_ff || access_ready;
   assign accept       = req_ch.valid && ready;
   assign req_ch.ready = ready;
   assign lanes        = lane_mask(req_ch.byte_enable);

   always_comb begin
      pixel_address = ADDR_BITS'(req_ch.pixel_y) * PITCH + ADDR_BITS'(req_ch.pixel_x)
                      + (control_ff[0] ? SCREEN1_BASE : '0);
      valid_in   = accept || (valid_ff && !access_ready);
      control_in = control_ff;
      mask_in    = mask_ff;
      access_in  = access_ff;
      if (accept) begin
         if (req_ch.func == FUNC_CTRL_WRITE) begin
            control_in = merge_word(control_ff, req_ch.write_data, lanes);
         end
         if (req_ch.func == FUNC_MASK_WRITE) begin
            mask_in = merge_word(mask_ff, req_ch.write_data, lanes);
         end
         access_in.func        = req_ch.func;
         access_in.write_data  = req_ch.write_data;
         access_in.bit_enable  = lanes & mask_ff;
         access_in.raw_address = (req_ch.func == FUNC_PIXEL_FETCH) ? pixel_address
                                                                   : req_ch.word_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         control_ff <= '0;
         mask_ff    <= '0;
      end else begin
         valid_ff   <= valid_in;
         control_ff <= control_in;
         mask_ff    <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      access_ff <= access_in;
   end

   assign access_valid = valid_ff;
   assign access_out   = access_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bvpd_wrap.sv =====
// Address wrap, first half: estimates the quotient of the raw address by the
// RAM depth with a reciprocal multiply. Depends on bvpd_pkg.
`default_nettype none

module bvpd_wrap #(
   parameter int RAM_WORDS = 262144
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      access_valid,
   output logic                      access_ready,
   input  bvpd_pkg::bvpd_access_type access_in_data,
   output logic                      slot_valid,
   input  logic                      slot_ready,
   output bvpd_pkg::bvpd_slot_type   slot_out
);
   import bvpd_pkg::*;

   localparam int RAM_BITS   = $clog2(RAM_WORDS);
   localparam int SHIFT      = ADDR_BITS + RAM_BITS;
   localparam int RECIP_BITS = ADDR_BITS + 2;
   localparam int PROD_BITS  = ADDR_BITS + RECIP_BITS;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(RAM_WORDS) - 64'd1) / 64'(RAM_WORDS);
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

   logic                 ready;
   logic                 fire;
   logic [PROD_BITS-1:0] product;
   logic                 valid_ff, valid_in;
   bvpd_slot_type        slot_ff, slot_in;

   assign ready        = !valid_ff || slot_ready;
   assign fire         = access_valid && ready;
   assign access_ready = ready;

   always_comb begin
      product  = PROD_BITS'(access_in_data.raw_address) * PROD_BITS'(RECIP);
      valid_in = fire || (valid_ff && !slot_ready);
      slot_in  = slot_ff;
      if (fire) begin
         slot_in.access   = access_in_data;
         slot_in.quotient = ADDR_BITS'(product >> SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_valid = valid_ff;
   assign slot_out   = slot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bvpd_ram.sv =====
// Video RAM stage: finishes the address wrap, performs the bit-masked write
// and the registered read. Depends on bvpd_pkg.
`default_nettype none

module bvpd_ram #(
   parameter int RAM_WORDS = 262144
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     slot_valid,
   output logic                     slot_ready,
   input  bvpd_pkg::bvpd_slot_type  slot_in_data,
   output logic                     fetch_valid,
   input  logic                     fetch_ready,
   output bvpd_pkg::bvpd_fetch_type fetch_out
);
   import bvpd_pkg::*;

   localparam int RAM_BITS = $clog2(RAM_WORDS);
   localparam logic [ADDR_BITS:0] MOD_N = (ADDR_BITS + 1)'(RAM_WORDS);

   logic                 ready;
   logic                 fire;
   logic                 write_en;
   logic [ADDR_BITS:0]   remainder;
   logic [ADDR_BITS:0]   wrapped;
   logic [RAM_BITS-1:0]  index;
   logic                 valid_ff, valid_in;
   logic [FUNC_BITS-1:0] func_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] mem [RAM_WORDS];

   assign ready      = !valid_ff || fetch_ready;
   assign fire       = slot_valid && ready;
   assign slot_ready = ready;
   assign write_en   = fire && (slot_in_data.access.func == FUNC_RAM_WRITE);

   always_comb begin
      remainder = {1'b0, slot_in_data.access.raw_address}
                  - (ADDR_BITS + 1)'(slot_in_data.quotient) * MOD_N;
      wrapped   = (remainder >= MOD_N) ? remainder - MOD_N : remainder;
      index     = wrapped[RAM_BITS-1:0];
      valid_in  = fire || (valid_ff && !fetch_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            if (slot_in_data.access.bit_enable[i]) begin
               mem[index][i] <= slot_in_data.access.write_data[i];
            end
         end
      end
      if (fire) begin
         word_ff <= mem[index];
         func_ff <= slot_in_data.access.func;
      end
   end

   assign fetch_valid    = valid_ff;
   assign fetch_out.func = func_ff;
   assign fetch_out.word = word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bvpd_out.sv =====
// Result stage: selects the read data and decodes the palette index into the
// response register. Depends on bvpd_pkg and bvpd_if.
`default_nettype none

module bvpd_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fetch_valid,
   output logic                     fetch_ready,
   input  bvpd_pkg::bvpd_fetch_type fetch_in_data,
   bvpd_rsp_if.source               rsp_ch
);
   import bvpd_pkg::*;

   logic                  ready;
   logic                  fire;
   logic                  valid_ff, valid_in;
   logic [WORD_BITS-1:0]  read_data_ff, read_data_in;
   logic [INDEX_BITS-1:0] palette_ff, palette_in;

   assign ready       = !valid_ff || rsp_ch.ready;
   assign fire        = fetch_valid && ready;
   assign fetch_ready = ready;

   always_comb begin
      valid_in     = fire || (valid_ff && !rsp_ch.ready);
      read_data_in = read_data_ff;
      palette_in   = palette_ff;
      if (fire) begin
         read_data_in = '0;
         palette_in   = '0;
         case (fetch_in_data.func)
            FUNC_RAM_READ:    read_data_in = fetch_in_data.word;
            FUNC_CTRL_READ:   read_data_in = STATUS_VALUE;
            FUNC_PIXEL_FETCH: palette_in   = decode_pixel(fetch_in_data.word);
            default: begin
               read_data_in = '0;
               palette_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      palette_ff   <= palette_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.read_data     = read_data_ff;
   assign rsp_ch.palette_index = palette_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_video_ram_pixel_decoder_unit.sv =====
// Top level of the bitmap video RAM pixel decoder.
// Depends on bvpd_pkg, bvpd_if, bvpd_front, bvpd_wrap, bvpd_ram and bvpd_out.
//
// Every request transfer yields exactly one response transfer, in order. The
// block is a four-stage pipeline that takes one request per clock unless the
// response side stalls: the request register forms the RAM address, the next
// stage estimates its quotient by the RAM depth, the third stage finishes the
// wrap and makes the single RAM access (a bit-masked write or a read with
// registered data), and the response register holds the result. The single
// RAM port, used once per item, sets the rate of one item per cycle when
// nothing stalls. Control and mask writes take effect for the very next
// request. The RAM is not cleared at reset, so a read of a word that was
// never written returns undefined data.
`default_nettype none

module bitmap_video_ram_pixel_decoder_unit #(
   parameter int RAM_WORDS  = 262144,
   parameter int LINE_PITCH = 512
) (
   input  logic       clock,
   input  logic       reset,
   bvpd_req_if.sink   req_ch,
   bvpd_rsp_if.source rsp_ch
);
   import bvpd_pkg::*;

   logic            access_valid, access_ready;
   logic            slot_valid, slot_ready;
   logic            fetch_valid, fetch_ready;
   bvpd_access_type access;
   bvpd_slot_type   slot;
   bvpd_fetch_type  fetch;

   bvpd_front #(
      .LINE_PITCH(LINE_PITCH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .access_valid(access_valid),
      .access_ready(access_ready),
      .access_out  (access)
   );

   bvpd_wrap #(
      .RAM_WORDS(RAM_WORDS)
   ) u_wrap (
      .clock         (clock),
      .reset         (reset),
      .access_valid  (access_valid),
      .access_ready  (access_ready),
      .access_in_data(access),
      .slot_valid    (slot_valid),
      .slot_ready    (slot_ready),
      .slot_out      (slot)
   );

   bvpd_ram #(
      .RAM_WORDS(RAM_WORDS)
   ) u_ram (
      .clock       (clock),
      .reset       (reset),
      .slot_valid  (slot_valid),
      .slot_ready  (slot_ready),
      .slot_in_data(slot),
      .fetch_valid (fetch_valid),
      .fetch_ready (fetch_ready),
      .fetch_out   (fetch)
   );

   bvpd_out u_out (
      .clock        (clock),
      .reset        (reset),
      .fetch_valid  (fetch_valid),
      .fetch_ready  (fetch_ready),
      .fetch_in_data(fetch),
      .rsp_ch       (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/core/bvpd_checker.sv =====
// Port-level checker for the bitmap video RAM pixel decoder, and the bind
// that attaches it to the top level. Depends on the top level's ports.
`default_nettype none

module bvpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] read_data,
   input logic [11:0] palette_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response valid dropped before its transfer.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(read_data) && $stable(palette_index))
      else $error("Stalled response payload changed.");

   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (palette_index != 12'd0) |-> read_data == 16'd0)
      else $error("A pixel fetch response carries read data.");

   a_index_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> palette_index[7:4] == 4'b0)
      else $error("Palette index bits 7 to 4 are not zero.");

   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("Request side not ready after reset.");

endmodule

bind bitmap_video_ram_pixel_decoder_unit bvpd_checker u_bvpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .read_data    (rsp_ch.read_data),
   .palette_index(rsp_ch.palette_index)
);

`default_nettype wire
